// ===== rtl/pqpp_pkg.sv =====
// Shared types and constants of the priority queue.
package pqpp_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned CountOutW   = 7;
  localparam int unsigned LimitW      = 7;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CfgIndexW   = 1;
  localparam int unsigned CfgDataW    = 7;
  localparam int unsigned CapacityDef = 64;

  localparam logic [LimitW-1:0] LimitReset = 7'd64;

  typedef enum logic [StatusW-1:0] {
    StatusDone  = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef enum logic {
    ReqPush = 1'b0,
    ReqPop  = 1'b1
  } req_e;

  typedef enum logic [CfgIndexW-1:0] {
    RegOrderMode     = 1'b0,
    RegCapacityLimit = 1'b1
  } reg_e;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                    push;
    logic                    pop_min;
    logic signed [DataW-1:0] value;
  } op_t;

endpackage

// ===== rtl/pqpp_cell.sv =====
// One cell of the sorted chain: holds one entry and trades it with its neighbors.
module pqpp_cell #(
  parameter int unsigned Idx    = 0,
  parameter int unsigned CountW = 7
) (
  input  logic                              clk_i,
  input  pqpp_pkg::op_t                     op_i,
  input  logic [CountW-1:0]                 count_i,
  input  logic signed [pqpp_pkg::DataW-1:0] lo_val_i,
  input  logic                              lo_gt_i,
  input  logic signed [pqpp_pkg::DataW-1:0] hi_val_i,
  output logic signed [pqpp_pkg::DataW-1:0] val_o,
  output logic                              gt_o,
  output logic [pqpp_pkg::DataW-1:0]        top_val_o
);
  import pqpp_pkg::*;

  localparam logic [CountW-1:0] IdxC = CountW'(Idx);
  localparam logic [CountW-1:0] TopC = CountW'(Idx + 1);

  logic signed [DataW-1:0] val_q, val_d;
  logic                    occupied;
  logic                    is_top;

  assign occupied = IdxC < count_i;
  assign is_top   = count_i == TopC;

  // Entries stay sorted ascending from cell 0 upward, so gt is false below
  // the insertion point and true from it on.
  assign gt_o = !occupied || (val_q > op_i.value);

  always_comb begin
    val_d = val_q;
    if (op_i.push) begin
      if (lo_gt_i) begin
        val_d = lo_val_i;
      end else if (gt_o) begin
        val_d = op_i.value;
      end
    end else if (op_i.pop_min) begin
      val_d = hi_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o     = val_q;
  assign top_val_o = is_top ? val_q : '0;

endmodule

// ===== rtl/priority_queue_push_pop.sv =====
// Top level of the bounded priority queue built as a sorted chain of cells.
// A result appears in the output register in the cycle after its request is taken.
// The input is busy after each taken request; the registered select of the top cell
// across the whole chain must refresh after each update before the next request.
// Reset clears the entry count, sets order_mode to 0 and capacity_limit to 64.
// The entry cells themselves are not cleared and need no clearing pass.
module priority_queue_push_pop #(
  parameter int unsigned Capacity = pqpp_pkg::CapacityDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                req_type_i,
  input  logic signed [pqpp_pkg::DataW-1:0]   push_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pqpp_pkg::StatusW-1:0]        status_o,
  output logic signed [pqpp_pkg::DataW-1:0]   popped_value_o,
  output logic [pqpp_pkg::CountOutW-1:0]      entry_count_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pqpp_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  logic [pqpp_pkg::CfgDataW-1:0]       cfg_data_i
);
  import pqpp_pkg::*;

  localparam int unsigned CountW = $clog2(Capacity + 1);
  localparam int unsigned CmpW   = (CountW > LimitW) ? CountW : LimitW;

  logic [CountW-1:0]        count_q, count_d;
  logic                     mode_q;
  logic [LimitW-1:0]        limit_q;
  logic                     busy_q;
  logic                     out_valid_q;
  status_e                  status_q, status_d;
  logic signed [DataW-1:0]  popped_q, popped_d;
  logic [CountOutW-1:0]     count_out_q;
  logic [DataW-1:0]         top_q, top_d;

  logic                     in_acc;
  logic                     is_push;
  logic                     full;
  logic                     empty;
  logic                     do_push;
  logic                     do_pop;
  op_t                      op;

  logic signed [DataW-1:0]  val_w [Capacity];
  logic                     gt_w  [Capacity];
  logic [DataW-1:0]         top_w [Capacity];

  assign in_stall_o  = busy_q || (out_valid_q && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign is_push = req_type_i == ReqPush;
  assign full    = (CmpW'(count_q) >= CmpW'(limit_q)) || (CmpW'(count_q) >= CmpW'(Capacity));
  assign empty   = count_q == '0;
  assign do_push = in_acc && is_push && !full;
  assign do_pop  = in_acc && !is_push && !empty;

  assign op.push    = do_push;
  assign op.pop_min = do_pop && mode_q;
  assign op.value   = push_value_i;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [DataW-1:0] lo_val;
    logic                    lo_gt;
    logic signed [DataW-1:0] hi_val;

    if (i == 0) begin : g_first
      assign lo_val = '0;
      assign lo_gt  = 1'b0;
    end else begin : g_inner_lo
      assign lo_val = val_w[i-1];
      assign lo_gt  = gt_w[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign hi_val = '0;
    end else begin : g_inner_hi
      assign hi_val = val_w[i+1];
    end

    pqpp_cell #(
      .Idx    (i),
      .CountW (CountW)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (op),
      .count_i   (count_q),
      .lo_val_i  (lo_val),
      .lo_gt_i   (lo_gt),
      .hi_val_i  (hi_val),
      .val_o     (val_w[i]),
      .gt_o      (gt_w[i]),
      .top_val_o (top_w[i])
    );
  end

  // At most one cell flags itself as top, so an OR over the chain selects it.
  always_comb begin
    top_d = '0;
    for (int i = 0; i < Capacity; i++) begin
      top_d = top_d | top_w[i];
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = StatusDone;
    popped_d = '0;
    if (is_push) begin
      if (full) begin
        status_d = StatusFull;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end else begin
      if (empty) begin
        status_d = StatusEmpty;
      end else begin
        count_d  = count_q - CountW'(1);
        popped_d = mode_q ? val_w[0] : $signed(top_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      mode_q      <= 1'b0;
      limit_q     <= LimitReset;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= in_acc;
      if (in_acc) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          RegOrderMode: begin
            mode_q <= cfg_data_i[0];
          end
          RegCapacityLimit: begin
            limit_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
    if (in_acc) begin
      status_q    <= status_d;
      popped_q    <= popped_d;
      count_out_q <= CountOutW'(count_d);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign popped_value_o = popped_q;
  assign entry_count_o  = count_out_q;

endmodule

// ===== tb/sv/pq_shadow_pkg.sv =====
`timescale 1ns / 1ps
// Shadow copy of the priority queue that predicts and checks each result.
package pq_shadow_pkg;

  import pqpp_pkg::*;

  class pq_shadow;

    typedef struct {
      status_e                 status;
      logic signed [DataW-1:0] value;
      logic [CountOutW-1:0]    count;
    } result_t;

    logic signed [DataW-1:0] entries [CapacityDef];
    int unsigned             held;
    logic                    pop_least;
    logic [LimitW-1:0]       limit;
    result_t                 due_results [$];
    int unsigned             mismatches;

    function new();
      held       = 0;
      pop_least  = 1'b0;
      limit      = LimitReset;
      mismatches = 0;
    endfunction

    function void set_reg(input reg_e idx, input logic [CfgDataW-1:0] data);
      if (idx == RegOrderMode) begin
        pop_least = data[0];
      end else begin
        limit = data[LimitW-1:0];
      end
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(input req_e req, input logic signed [DataW-1:0] value);
      result_t     r;
      int unsigned cap;
      int unsigned best;
      int unsigned i;
      r.status = StatusDone;
      r.value  = '0;
      cap = (limit > CapacityDef) ? CapacityDef : limit;
      if (req == ReqPush) begin
        if (held >= cap) begin
          r.status = StatusFull;
        end else begin
          entries[held] = value;
          held++;
        end
      end else if (held == 0) begin
        r.status = StatusEmpty;
      end else begin
        best = 0;
        for (i = 1; i < held; i++) begin
          if (pop_least ? (entries[i] < entries[best]) : (entries[i] > entries[best])) begin
            best = i;
          end
        end
        r.value       = entries[best];
        entries[best] = entries[held - 1];
        held--;
      end
      r.count = CountOutW'(held);
      due_results.push_back(r);
    endfunction

    function void check_result(input logic [StatusW-1:0] status,
                               input logic signed [DataW-1:0] value,
                               input logic [CountOutW-1:0] count);
      result_t e;
      if (due_results.size() == 0) begin
        $display("%0t: unexpected result: status %0d value %0d count %0d",
                 $time, status, value, count);
        mismatches++;
        return;
      end
      e = due_results.pop_front();
      if (status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, status);
        mismatches++;
      end
      if (value !== e.value) begin
        $display("%0t: popped_value expected %0d actual %0d", $time, e.value, value);
        mismatches++;
      end
      if (count !== e.count) begin
        $display("%0t: entry_count expected %0d actual %0d", $time, e.count, count);
        mismatches++;
      end
    endfunction

  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the priority queue testbench: clock, reset, request drivers and result monitor.
module tb_top;

  import pqpp_pkg::*;
  import pq_shadow_pkg::*;

  localparam int unsigned Phases        = 12;
  localparam int unsigned ItemsPerPhase = 75;
  localparam int unsigned IdleSettle    = 4;
  localparam int unsigned QuietLimit    = 1000;

  localparam logic signed [DataW-1:0] MaxVal = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] MinVal = 32'sh8000_0000;

  logic                        clk_i;
  logic                        rst_ni         = 1'b0;
  logic                        in_valid_i     = 1'b0;
  logic                        in_stall_o;
  logic                        req_type_i     = ReqPush;
  logic signed [DataW-1:0]     push_value_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i    = 1'b0;
  logic [StatusW-1:0]          status_o;
  logic signed [DataW-1:0]     popped_value_o;
  logic [CountOutW-1:0]        entry_count_o;
  logic                        cfg_valid_i    = 1'b0;
  logic                        cfg_ready_o;
  logic [CfgIndexW-1:0]        cfg_index_i    = RegOrderMode;
  logic [CfgDataW-1:0]         cfg_data_i     = '0;

  pq_shadow sb = new();
  bit       in_calm = 1'b0;

  priority_queue_push_pop dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .entry_count_o  (entry_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned in_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (in_calm || pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Half full-range values, the rest clusters of small, extreme and repeated values.
  function automatic logic signed [DataW-1:0] rand_value();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return $urandom;
    if (pick < 7) return $urandom_range(0, 8) - 4;
    if (pick == 7) begin
      case ($urandom_range(0, 3))
        0:       return MaxVal;
        1:       return MinVal;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom_range(0, 2000) - 1000;
  endfunction

  task automatic request(input req_e req, input logic signed [DataW-1:0] value);
    int unsigned gap;
    gap = in_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    push_value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req, value);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CfgDataW-1:0] data, input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
    if (last) begin
      cfg_valid_i <= 1'b0;
    end
  endtask

  // Registers are only touched once every request has produced its result.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (IdleSettle) @(posedge clk_i);
  endtask

  initial begin : result_side
    int unsigned seg_left;
    logic        stalled;
    seg_left = 0;
    stalled  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        sb.check_result(status_o, popped_value_o, entry_count_o);
      end
      if (seg_left == 0) begin
        stalled = !stalled;
        if (stalled) begin
          seg_left = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 2) :
                     ($urandom_range(0, 99) < 75) ? $urandom_range(3, 6) :
                                                    $urandom_range(10, 40);
        end else begin
          seg_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) :
                                                    $urandom_range(30, 100);
        end
      end
      seg_left--;
      out_stall_i <= stalled;
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned         phase;
    int unsigned         k;
    int unsigned         push_pct;
    int unsigned         lim;
    logic [CfgDataW-1:0] cfg;
    req_e                req;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty queue, then the value extremes and a duplicate in max order.
    request(ReqPop, MaxVal);
    request(ReqPush, MaxVal);
    request(ReqPush, MinVal);
    request(ReqPush, '0);
    request(ReqPush, -1);
    request(ReqPush, 1);
    request(ReqPush, 1);
    request(ReqPop, '0);
    request(ReqPop, MinVal);
    request(ReqPop, -1);

    // Switch to min order while entries are still held.
    wait_idle();
    write_reg(RegOrderMode, 7'd1, 1'b1);
    request(ReqPop, MaxVal);

    // Limit lowered below the count: pushes are refused, pops still work.
    wait_idle();
    write_reg(RegCapacityLimit, 7'd1, 1'b1);
    request(ReqPush, 7);
    request(ReqPop, '0);
    request(ReqPush, 8);
    request(ReqPop, '0);
    request(ReqPop, '0);

    // A zero limit refuses every push.
    wait_idle();
    write_reg(RegCapacityLimit, 7'd0, 1'b1);
    request(ReqPush, MaxVal);
    request(ReqPush, MinVal);
    request(ReqPop, '0);

    for (phase = 0; phase < Phases; phase++) begin
      wait_idle();
      case (phase % 6)
        0:       lim = 127;
        1:       lim = 64;
        2:       lim = $urandom_range(1, 8);
        3:       lim = 0;
        4:       lim = $urandom_range(65, 126);
        default: lim = $urandom_range(0, 127);
      endcase
      case (phase % 4)
        0:       push_pct = 90;
        1:       push_pct = 50;
        2:       push_pct = 25;
        default: push_pct = 70;
      endcase
      // Only bit zero of the order register matters; the rest is noise.
      cfg    = CfgDataW'($urandom);
      cfg[0] = (phase < 2) ? phase[0] : 1'($urandom_range(0, 1));
      write_reg(RegOrderMode, cfg, 1'b0);
      write_reg(RegCapacityLimit, CfgDataW'(lim), 1'b1);
      in_calm = ($urandom_range(0, 3) == 0);
      for (k = 0; k < ItemsPerPhase; k++) begin
        req = ($urandom_range(0, 99) < push_pct) ? ReqPush : ReqPop;
        request(req, rand_value());
      end
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (sb.due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.due_results.size());
      sb.mismatches++;
    end
    if (sb.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
